>>> hdl/arp_pkg.sv
// Shared types and codes for the ARP cache resolver.
`default_nettype none

package arp_pkg;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } entry_type;

   localparam logic [1:0] FN_QUERY  = 2'd0;
   localparam logic [1:0] FN_INSERT = 2'd1;
   localparam logic [1:0] FN_PACKET = 2'd2;

   localparam logic [1:0] SEND_NONE  = 2'd0;
   localparam logic [1:0] SEND_REQ   = 2'd1;
   localparam logic [1:0] SEND_REPLY = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD     = 2'd1;
   localparam logic [1:0] STAT_FOREIGN = 2'd2;

   localparam logic [15:0] HTYPE_ETH  = 16'h0001;
   localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  HLEN_MAC   = 8'd6;
   localparam logic [7:0]  PLEN_IPV4  = 8'd4;
   localparam logic [15:0] OP_REQUEST = 16'h0001;

endpackage

`default_nettype wire

>>> hdl/arp_cache_resolver_top.sv
// ARP cache resolver: address table in one synchronous memory, scanned one entry per cycle.
//
// After reset the block clears its table entry by entry, during which req_stall
// stays high (the csr port is always ready). Each item is then taken in, the table
// entries are read in order until the first match or the last entry, each read
// entry is compared as it arrives, and the result and any table update are written
// back; a malformed or foreign packet or an unused func code skips the scan. The
// single read port of the table memory, stepping through the entries in order,
// sets the scan time. One item is worked at a time; the next is taken as soon as
// the previous result sits in the output register.
`default_nettype none

module arp_cache_resolver_top #(
   parameter int ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_item_ip,
   input  wire logic [47:0] req_item_mac,
   input  wire logic [31:0] req_packet_target_ip,
   input  wire logic [15:0] req_hard_type,
   input  wire logic [15:0] req_prot_type,
   input  wire logic [7:0]  req_hard_len,
   input  wire logic [7:0]  req_prot_len,
   input  wire logic [15:0] req_opcode,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [47:0]      rsp_result_mac,
   output logic [1:0]       rsp_send,
   output logic [31:0]      rsp_send_ip,
   output logic [47:0]      rsp_send_mac,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);
   import arp_pkg::*;

   localparam int IDXW = $clog2(ENTRIES);
   localparam int CNTW = IDXW + 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

   entry_type mem [ENTRIES];

   state_type state_ff, state_in;
   logic [31:0] own_ip_ff;
   logic [IDXW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [IDXW-1:0] slot_ff, slot_in;
   logic [CNTW-1:0] scan_cnt_ff, scan_cnt_in;
   logic data_vld_ff, data_vld_in;
   logic [IDXW-1:0] data_idx_ff;
   entry_type rd_data_ff;

   logic [1:0]  func_ff, func_in;
   logic [31:0] ip_ff, ip_in;
   logic [47:0] mac_ff, mac_in;
   logic [1:0]  stat_ff, stat_in;
   logic        opreq_ff, opreq_in;
   logic        hit_ff, hit_in;
   logic [IDXW-1:0] hit_idx_ff, hit_idx_in;
   logic [47:0] hit_mac_ff, hit_mac_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [47:0] rsp_result_mac_ff, rsp_result_mac_in;
   logic [1:0]  rsp_send_ff, rsp_send_in;
   logic [31:0] rsp_send_ip_ff, rsp_send_ip_in;
   logic [47:0] rsp_send_mac_ff, rsp_send_mac_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic            wr_en;
   logic [IDXW-1:0] wr_addr;
   entry_type       wr_data;
   logic            issue;
   logic            out_free;
   logic [1:0]      pkt_stat;

   assign csr_ready = 1'b1;
   assign issue = (state_ff == ST_SCAN) && (scan_cnt_ff < CNTW'(ENTRIES));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (req_hard_type != HTYPE_ETH || req_hard_len != HLEN_MAC ||
          req_prot_type != PTYPE_IPV4 || req_prot_len != PLEN_IPV4) begin
         pkt_stat = STAT_BAD;
      end else if (req_packet_target_ip != own_ip_ff) begin
         pkt_stat = STAT_FOREIGN;
      end else begin
         pkt_stat = STAT_OK;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      slot_in     = slot_ff;
      scan_cnt_in = scan_cnt_ff;
      data_vld_in = issue;
      func_in     = func_ff;
      ip_in       = ip_ff;
      mac_in      = mac_ff;
      stat_in     = stat_ff;
      opreq_in    = opreq_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_mac_in  = hit_mac_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_found_in      = rsp_found_ff;
      rsp_result_mac_in = rsp_result_mac_ff;
      rsp_send_in       = rsp_send_ff;
      rsp_send_ip_in    = rsp_send_ip_ff;
      rsp_send_mac_in   = rsp_send_mac_ff;
      rsp_status_in     = rsp_status_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_data   = '0;
      req_stall = (state_ff != ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in     = req_func;
               ip_in       = req_item_ip;
               mac_in      = req_item_mac;
               stat_in     = (req_func == FN_PACKET) ? pkt_stat : STAT_OK;
               opreq_in    = (req_opcode == OP_REQUEST);
               hit_in      = 1'b0;
               scan_cnt_in = '0;
               if (req_func inside {FN_QUERY, FN_INSERT} ||
                   (req_func == FN_PACKET && pkt_stat == STAT_OK)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            // Data read last cycle belongs to data_idx_ff; the first match wins.
            if (data_vld_ff && rd_data_ff.ip == ip_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = data_idx_ff;
               hit_mac_in = rd_data_ff.mac;
               state_in   = ST_FINISH;
            end else if (data_vld_ff && data_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_found_in      = 1'b0;
               rsp_result_mac_in = '0;
               rsp_send_in       = SEND_NONE;
               rsp_send_ip_in    = '0;
               rsp_send_mac_in   = '0;
               rsp_status_in     = stat_ff;
               state_in          = ST_IDLE;
               case (func_ff)
                  FN_QUERY: begin
                     if (hit_ff) begin
                        rsp_found_in      = 1'b1;
                        rsp_result_mac_in = hit_mac_ff;
                     end else begin
                        wr_en          = 1'b1;
                        wr_data.ip     = ip_ff;
                        rsp_send_in    = SEND_REQ;
                        rsp_send_ip_in = ip_ff;
                     end
                  end
                  FN_INSERT, FN_PACKET: begin
                     if (stat_ff == STAT_OK) begin
                        wr_en       = 1'b1;
                        wr_data.ip  = ip_ff;
                        wr_data.mac = mac_ff;
                        if (hit_ff) begin
                           wr_addr = hit_idx_ff;
                        end
                        if (func_ff == FN_PACKET && opreq_ff) begin
                           rsp_send_in     = SEND_REPLY;
                           rsp_send_ip_in  = ip_ff;
                           rsp_send_mac_in = mac_ff;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = STAT_OK;
                  end
               endcase
               // A new entry takes the round-robin slot.
               if (wr_en && !hit_ff) begin
                  slot_in = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[scan_cnt_ff[IDXW-1:0]];
      data_idx_ff <= scan_cnt_ff[IDXW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         own_ip_ff    <= '0;
         clr_cnt_ff   <= '0;
         slot_ff      <= '0;
         scan_cnt_ff  <= '0;
         data_vld_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         slot_ff      <= slot_in;
         scan_cnt_ff  <= scan_cnt_in;
         data_vld_ff  <= data_vld_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            own_ip_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff           <= func_in;
      ip_ff             <= ip_in;
      mac_ff            <= mac_in;
      stat_ff           <= stat_in;
      opreq_ff          <= opreq_in;
      hit_idx_ff        <= hit_idx_in;
      hit_mac_ff        <= hit_mac_in;
      rsp_found_ff      <= rsp_found_in;
      rsp_result_mac_ff <= rsp_result_mac_in;
      rsp_send_ff       <= rsp_send_in;
      rsp_send_ip_ff    <= rsp_send_ip_in;
      rsp_send_mac_ff   <= rsp_send_mac_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_result_mac = rsp_result_mac_ff;
   assign rsp_send       = rsp_send_ff;
   assign rsp_send_ip    = rsp_send_ip_ff;
   assign rsp_send_mac   = rsp_send_mac_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> hdl/arp_cache_resolver_chk.sv
// Port-level checker for the ARP cache resolver and its bind.
`default_nettype none

module arp_cache_resolver_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_found,
   input wire logic [1:0]  rsp_send,
   input wire logic [31:0] rsp_send_ip,
   input wire logic [47:0] rsp_send_mac,
   input wire logic [1:0]  rsp_status
);
   import arp_pkg::*;

   // A stalled result beat stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_found_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_send == SEND_NONE && rsp_status == STAT_OK)
      else $error("hit also sends or reports a packet status");

   a_no_send_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send == SEND_NONE |-> rsp_send_ip == '0 && rsp_send_mac == '0)
      else $error("send address set with nothing to send");

   a_request_bcast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send == SEND_REQ |-> rsp_send_mac == '0 && !rsp_found)
      else $error("broadcast request carries a destination MAC");

   a_drop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_send == SEND_NONE && !rsp_found)
      else $error("dropped packet produced an action");

endmodule

bind arp_cache_resolver_top arp_cache_resolver_chk u_chk (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_found    (rsp_found),
   .rsp_send     (rsp_send),
   .rsp_send_ip  (rsp_send_ip),
   .rsp_send_mac (rsp_send_mac),
   .rsp_status   (rsp_status)
);

`default_nettype wire
